>>> sv/lc3_subset_instruction_step_unit_assert.svh
// Assertion macros shared by the instruction step unit.
`ifndef LC3_SUBSET_INSTRUCTION_STEP_UNIT_ASSERT_SVH
`define LC3_SUBSET_INSTRUCTION_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LC3_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lc3 step unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LC3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lc3 step unit: next-cycle check failed");

`endif

>>> sv/lc3_pkg.sv
// Constants, opcodes and helper functions of the LC-3 subset step unit.
package lc3_pkg;

	localparam int MEM_WORDS = 256;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int WORD_W = 16;

	localparam logic [3:0] OP_BR = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_LD = 4'd2;
	localparam logic [3:0] OP_NOT = 4'd9;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [7:0] TRAP_OUT = 8'd33;
	localparam logic [7:0] TRAP_HALT = 8'd37;

	localparam logic [2:0] CC_NEG = 3'd4;
	localparam logic [2:0] CC_ZERO = 3'd2;
	localparam logic [2:0] CC_POS = 3'd1;
	localparam logic [2:0] NZP_NONE = 3'd0;
	localparam logic [2:0] NZP_ALL = 3'd7;

	typedef logic [WORD_W-1:0] word_t;

	function automatic logic [2:0] flags_of(input word_t v);
		logic [2:0] f;
		if (v[WORD_W-1]) begin
			f = CC_NEG;
		end else if (v == '0) begin
			f = CC_ZERO;
		end else begin
			f = CC_POS;
		end
		return f;
	endfunction

	function automatic word_t sext9(input word_t ir);
		return {{(WORD_W - 9){ir[8]}}, ir[8:0]};
	endfunction

	function automatic word_t sext5(input word_t ir);
		return {{(WORD_W - 5){ir[4]}}, ir[4:0]};
	endfunction

endpackage

>>> sv/lc3_subset_instruction_step_unit.sv
// LC-3 subset step unit: program memory loads and single-instruction execution.
// An accepted word passes stage 1 (decode) and stage 2 (execute) into the output register;
// no new word is taken while one is in stage 1 or held in stage 2. The fetch read at
// acceptance and the LD read in the next cycle share one read port of program memory.
// Reset (async, active low): pc and condition code clear, memory reads as zero and
// register i reads as i through per-entry valid flags; no clearing pass is needed.
`include "lc3_subset_instruction_step_unit_assert.svh"

module lc3_subset_instruction_step_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  load_address,
	input  logic [15:0] load_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pc_after,
	output logic [15:0] instruction,
	output logic [2:0]  cond_flags,
	output logic        reg_written,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic        char_valid,
	output logic [7:0]  char_out,
	output logic        halt_seen
);

	localparam int AW = lc3_pkg::MEM_AW;

	// Architectural state.
	lc3_pkg::word_t pc_q;
	logic [2:0] cc_q;
	lc3_pkg::word_t main_mem_q [lc3_pkg::MEM_WORDS];
	logic [lc3_pkg::MEM_WORDS-1:0] mem_vld_q;
	lc3_pkg::word_t rf_mem_q [8];
	logic [7:0] rf_vld_q;

	// Program memory read port.
	lc3_pkg::word_t mem_rd_q;
	logic mem_rd_ok_q;

	// Pipeline.
	logic v_s1, v_s2;
	logic action_s1;
	lc3_pkg::word_t instr_s2;
	logic ld_ok_s2;
	lc3_pkg::word_t rf_a_s2, rf_b_s2;
	logic rf_a_vld_s2, rf_b_vld_s2;
	logic [2:0] rf_a_idx_s2, rf_b_idx_s2;

	// Output register.
	logic out_valid_q;
	lc3_pkg::word_t pc_after_q, instr_q, reg_value_q;
	logic [2:0] cond_flags_q, reg_index_q;
	logic reg_written_q, char_valid_q, halt_seen_q;
	logic [7:0] char_out_q;

	logic in_accept, adv_s2;

	assign adv_s2 = v_s2 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 || (v_s2 && !adv_s2);
	assign in_accept = in_valid && !in_stall;

	// Stage 1 decode: branch decision, PC-relative address and register read ports.
	lc3_pkg::word_t instr_s1, pc_sum_s1;
	logic [3:0] op_s1;
	logic br_take_s1, ld_ok_s1, is_ld_s1;
	logic [2:0] rf_a_addr_s1, rf_b_addr_s1;

	always_comb begin
		instr_s1 = (action_s1 && mem_rd_ok_q) ? mem_rd_q : '0;
		op_s1 = instr_s1[15:12];
		pc_sum_s1 = pc_q + lc3_pkg::sext9(instr_s1);
		br_take_s1 = (instr_s1[11:9] == lc3_pkg::NZP_NONE)
			|| (instr_s1[11:9] == lc3_pkg::NZP_ALL)
			|| ((instr_s1[11:9] & cc_q) != 3'd0);
		is_ld_s1 = (op_s1 == lc3_pkg::OP_LD);
		ld_ok_s1 = is_ld_s1 && (32'(pc_sum_s1) < lc3_pkg::MEM_WORDS);
		rf_a_addr_s1 = (op_s1 == lc3_pkg::OP_TRAP) ? 3'd0 : instr_s1[8:6];
		rf_b_addr_s1 = instr_s1[2:0];
	end

	// Program memory: the load write at acceptance, one read a cycle.
	logic [AW-1:0] fetch_idx, ld_idx, rd_idx, wr_idx;
	logic fetch_ok, rd_en, rd_ok, wr_en;

	always_comb begin
		fetch_idx = AW'(pc_q);
		ld_idx = AW'(pc_sum_s1);
		fetch_ok = 32'(pc_q) < lc3_pkg::MEM_WORDS;
		wr_idx = AW'(load_address);
		wr_en = in_accept && !action && (32'(load_address) < lc3_pkg::MEM_WORDS);
		if (v_s1) begin
			rd_idx = ld_idx;
			rd_en = is_ld_s1;
			rd_ok = ld_ok_s1;
		end else begin
			rd_idx = fetch_idx;
			rd_en = in_accept && action;
			rd_ok = fetch_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			main_mem_q[wr_idx] <= load_data;
		end
		if (rd_en) begin
			mem_rd_q <= main_mem_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
			mem_rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				mem_vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				mem_rd_ok_q <= rd_ok && mem_vld_q[rd_idx];
			end
		end
	end

	// Register file reads issued from stage 1.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			rf_a_s2 <= rf_mem_q[rf_a_addr_s1];
			rf_b_s2 <= rf_mem_q[rf_b_addr_s1];
			rf_a_vld_s2 <= rf_vld_q[rf_a_addr_s1];
			rf_b_vld_s2 <= rf_vld_q[rf_b_addr_s1];
			rf_a_idx_s2 <= rf_a_addr_s1;
			rf_b_idx_s2 <= rf_b_addr_s1;
			instr_s2 <= instr_s1;
			ld_ok_s2 <= ld_ok_s1;
		end
		if (in_accept) begin
			action_s1 <= action;
		end
	end

	// Stage 2 execute.
	lc3_pkg::word_t ra, rb, opb, wval;
	logic [3:0] op_s2;
	logic wr, chv, halt;
	logic [2:0] widx, cc_new;
	logic [7:0] ch;

	always_comb begin
		ra = rf_a_vld_s2 ? rf_a_s2 : lc3_pkg::WORD_W'(rf_a_idx_s2);
		rb = rf_b_vld_s2 ? rf_b_s2 : lc3_pkg::WORD_W'(rf_b_idx_s2);
		opb = instr_s2[5] ? lc3_pkg::sext5(instr_s2) : rb;
		op_s2 = instr_s2[15:12];
		wr = 1'b0;
		wval = '0;
		chv = 1'b0;
		halt = 1'b0;
		ch = '0;
		case (op_s2)
			lc3_pkg::OP_NOT: begin
				wr = 1'b1;
				wval = ~ra;
			end
			lc3_pkg::OP_ADD: begin
				wr = 1'b1;
				wval = ra + opb;
			end
			lc3_pkg::OP_LD: begin
				wr = ld_ok_s2;
				wval = (ld_ok_s2 && mem_rd_ok_q) ? mem_rd_q : '0;
			end
			lc3_pkg::OP_TRAP: begin
				if (instr_s2[7:0] == lc3_pkg::TRAP_OUT) begin
					chv = 1'b1;
					ch = ra[7:0];
				end else if (instr_s2[7:0] == lc3_pkg::TRAP_HALT) begin
					halt = 1'b1;
				end
			end
			default: begin
			end
		endcase
		widx = wr ? instr_s2[11:9] : 3'd0;
		cc_new = wr ? lc3_pkg::flags_of(wval) : cc_q;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && wr) begin
			rf_mem_q[widx] <= wval;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q <= '0;
			cc_q <= '0;
			rf_vld_q <= '0;
		end else begin
			v_s1 <= in_accept;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// The fetch increments at acceptance; a taken branch adds its offset in stage 1.
			if (in_accept && action) begin
				pc_q <= pc_q + 1'b1;
			end else if (v_s1 && op_s1 == lc3_pkg::OP_BR && action_s1 && br_take_s1) begin
				pc_q <= pc_sum_s1;
			end
			if (adv_s2) begin
				cc_q <= cc_new;
				if (wr) begin
					rf_vld_q[widx] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pc_after_q <= pc_q;
			instr_q <= instr_s2;
			cond_flags_q <= cc_new;
			reg_written_q <= wr;
			reg_index_q <= widx;
			reg_value_q <= wval;
			char_valid_q <= chv;
			char_out_q <= ch;
			halt_seen_q <= halt;
		end
	end

	assign out_valid = out_valid_q;
	assign pc_after = pc_after_q;
	assign instruction = instr_q;
	assign cond_flags = cond_flags_q;
	assign reg_written = reg_written_q;
	assign reg_index = reg_index_q;
	assign reg_value = reg_value_q;
	assign char_valid = char_valid_q;
	assign char_out = char_out_q;
	assign halt_seen = halt_seen_q;

	`LC3_ASSERT_NOW(a_single_item_in_flight, v_s1, !v_s2)
	`LC3_ASSERT_NEXT(a_accept_enters_s1, in_accept, v_s1 && !v_s2)
	`LC3_ASSERT_NOW(a_flags_onehot, out_valid_q, $onehot0(cond_flags_q))
	`LC3_ASSERT_NOW(a_no_write_no_value, out_valid_q && !reg_written_q,
		reg_value_q == '0 && reg_index_q == 3'd0)

endmodule
